// File: hw/rtl/bfst_pkg.sv
package bfst_pkg;

  // table geometry
  localparam int unsigned Symbols    = 256;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned SymW       = $clog2(Symbols);
  localparam int unsigned KeyW       = CountWidth + SymW;

  // port widths fixed by the interface
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OutCntW = 16;
  localparam int unsigned ExtW    = (CountWidth > OutCntW) ? CountWidth : OutCntW;

  // request codes
  localparam logic ReqCount   = 1'b0;
  localparam logic ReqReadout = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CNT_WR = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic cnt_rd;     // read the counter addressed by the incoming byte
    logic cnt_wr;     // write back the incremented counter
    logic scan_init;  // reset scan address and best/second trackers
    logic scan_rd;    // issue the scan read at the scan address
    logic emit;       // load the result register, move cursor or clear
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan address is at the last entry
  } sts_t;

endpackage

// File: hw/rtl/bfst_ctrl.sv
module bfst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          req_type_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bfst_pkg::sts_t sts_i,
  output bfst_pkg::cmd_t cmd_o
);
  import bfst_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type_i == ReqCount) begin
            cmd_o.cnt_rd = 1'b1;
            state_d      = ST_CNT_WR;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_CNT_WR: begin
        cmd_o.cnt_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/bfst_dp.sv
module bfst_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bfst_pkg::ByteW-1:0]          data_byte_i,
  input  bfst_pkg::cmd_t                      cmd_i,
  output bfst_pkg::sts_t                      sts_o,
  output logic [bfst_pkg::ByteW-1:0]          symbol_o,
  output logic [bfst_pkg::OutCntW-1:0]        count_o,
  output logic                                is_last_o,
  output logic                                none_left_o
);
  import bfst_pkg::*;

  // counter memory; an entry whose valid bit is clear reads as zero
  logic [CountWidth-1:0] mem_q [Symbols];
  logic [Symbols-1:0]    vld_q;

  logic [SymW-1:0]       rd_addr;
  logic [CountWidth-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic [CountWidth-1:0] cnt_cur;
  logic [CountWidth-1:0] cnt_inc;

  logic [SymW-1:0]       byte_q;
  logic                  byte_ok_q;
  logic                  byte_ok;

  logic [SymW-1:0]       scan_q;
  logic                  proc_q;
  logic [SymW-1:0]       proc_sym_q;

  logic [KeyW-1:0]       best_q, best_d, sec_q, sec_d;
  logic                  best_hit_q, best_hit_d, sec_hit_q, sec_hit_d;
  logic [KeyW-1:0]       cur_q;
  logic                  started_q;

  logic [KeyW-1:0]       key;
  logic                  hit;

  logic [CountWidth-1:0] best_cnt;
  logic [ExtW-1:0]       best_ext;

  logic [ByteW-1:0]      symbol_q;
  logic [OutCntW-1:0]    count_q;
  logic                  is_last_q, none_left_q;

  assign byte_ok = ({1'b0, data_byte_i} < (ByteW + 1)'(Symbols));
  assign rd_addr = cmd_i.cnt_rd ? data_byte_i[SymW-1:0] : scan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr && byte_ok_q) begin
      mem_q[byte_q] <= cnt_inc;
    end
    rd_data_q <= mem_q[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
    if (cmd_i.cnt_rd) begin
      byte_q    <= data_byte_i[SymW-1:0];
      byte_ok_q <= byte_ok;
    end
  end

  assign cnt_cur = rd_vld_q ? rd_data_q : '0;
  assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;

  // scan compare stage: keep smallest and next smallest key above cursor
  assign key = {cnt_cur, proc_sym_q};
  assign hit = proc_q && (cnt_cur != '0) && (!started_q || (key > cur_q));

  always_comb begin
    best_d     = best_q;
    best_hit_d = best_hit_q;
    sec_d      = sec_q;
    sec_hit_d  = sec_hit_q;
    if (cmd_i.scan_init) begin
      best_hit_d = 1'b0;
      sec_hit_d  = 1'b0;
    end else if (hit) begin
      if (!best_hit_q || (key < best_q)) begin
        sec_d      = best_q;
        sec_hit_d  = best_hit_q;
        best_d     = key;
        best_hit_d = 1'b1;
      end else if (!sec_hit_q || (key < sec_q)) begin
        sec_d     = key;
        sec_hit_d = 1'b1;
      end
    end
  end

  assign best_cnt = best_q[KeyW-1:SymW];
  assign best_ext = ExtW'(best_cnt);

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    sec_q      <= sec_d;
    proc_sym_q <= scan_q;
    if (cmd_i.emit) begin
      if (best_hit_q) begin
        symbol_q    <= ByteW'(best_q[SymW-1:0]);
        count_q     <= (best_ext > ExtW'({OutCntW{1'b1}})) ? '1 : best_ext[OutCntW-1:0];
        is_last_q   <= !sec_hit_q;
        none_left_q <= 1'b0;
      end else begin
        symbol_q    <= '0;
        count_q     <= '0;
        is_last_q   <= 1'b0;
        none_left_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      scan_q     <= '0;
      proc_q     <= 1'b0;
      best_hit_q <= 1'b0;
      sec_hit_q  <= 1'b0;
      cur_q      <= '0;
      started_q  <= 1'b0;
    end else begin
      proc_q     <= cmd_i.scan_rd;
      best_hit_q <= best_hit_d;
      sec_hit_q  <= sec_hit_d;
      if (cmd_i.scan_init) begin
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.cnt_wr && byte_ok_q) begin
        vld_q[byte_q] <= 1'b1;
      end
      if (cmd_i.emit && best_hit_q) begin
        if (!sec_hit_q) begin
          vld_q     <= '0;
          cur_q     <= '0;
          started_q <= 1'b0;
        end else begin
          cur_q     <= best_q;
          started_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.scan_last = (scan_q == SymW'(Symbols - 1));

  assign symbol_o    = symbol_q;
  assign count_o     = count_q;
  assign is_last_o   = is_last_q;
  assign none_left_o = none_left_q;

endmodule

// File: hw/rtl/byte_frequency_sorted_table.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    req_type_i, data_byte_i
// out       output     out_valid_o / out_stall_i  symbol_o, count_o, is_last_o, none_left_o
//
// Count transaction: counter read, then saturating write-back.
// Readout transaction: a one-entry-per-cycle scan of the counter memory
// through its single read port, then a drain step and a result-load step.
// Reset clears the controller, the cursor and all per-entry valid bits; the
// counter memory itself is never cleared, a clear valid bit reads as zero.
// The result register decouples the sides: new transactions are taken while a
// result is stalled; a second readout waits at result load until it frees.
module byte_frequency_sorted_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [bfst_pkg::ByteW-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bfst_pkg::ByteW-1:0]   symbol_o,
  output logic [bfst_pkg::OutCntW-1:0] count_o,
  output logic                         is_last_o,
  output logic                         none_left_o
);
  import bfst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle / count write-back / scan / drain / result load
  bfst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counter memory, scan compare and result register
  bfst_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_byte_i(data_byte_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .symbol_o   (symbol_o),
    .count_o    (count_o),
    .is_last_o  (is_last_o),
    .none_left_o(none_left_o)
  );

`ifndef SYNTHESIS
  // an exhausted readout never also claims to be the last entry
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_last_o && none_left_o))
    else $error("is_last and none_left both set");

  // an exhausted readout carries an all-zero entry
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_left_o) |-> (count_o == '0 && symbol_o == '0))
    else $error("none_left result with nonzero payload");

  // a real entry always has a nonzero count
  a_entry_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !none_left_o) |-> (count_o != '0))
    else $error("readout entry with zero count");

  // a count transaction holds off input for its write-back cycle
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == ReqCount) |=> in_stall_o)
    else $error("input taken during counter write-back");
`endif

endmodule
